@@ hw/rtl/glyph_table_dedup_top_defines.svh @@
// Assertion macros shared by the glyph table dedup RTL.
// Depends on nothing; expects clk_i and rst_ni in the including module.
`ifndef GLYPH_TABLE_DEDUP_TOP_DEFINES_SVH
`define GLYPH_TABLE_DEDUP_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Antecedent implies consequent in the same cycle.
`define GTD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Antecedent implies consequent in the next cycle.
`define GTD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GTD_ASSERT_SAME(label, ante, cons, msg)
`define GTD_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

@@ hw/rtl/gtd_pkg.sv @@
// Package for the glyph table dedup block: geometry constants, codes, types.
// No dependencies.
package gtd_pkg;

  localparam int unsigned ROWS     = 8;
  localparam int unsigned ROW_BITS = 5;
  localparam int unsigned SLOTS    = 8;

  localparam int unsigned PAT_W    = 40;
  localparam int unsigned USED_W   = ROWS * ROW_BITS;
  localparam int unsigned IDX_W    = 3;   // glyph_id field width
  localparam int unsigned CNT_W    = 4;   // glyph count / limit width
  localparam int unsigned S_DATA_W = 48;  // 40 + 4 + 2, padded to bytes
  localparam int unsigned M_DATA_W = 56;  // 3 + 40 + 4 + 2, padded to bytes

  localparam logic [PAT_W:0]   PAT_ONE   = (PAT_W + 1)'(1);
  localparam logic [PAT_W-1:0] USED_MASK = PAT_W'((PAT_ONE << USED_W) - PAT_ONE);
  localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);
  localparam logic [CNT_W-1:0] MAX_GLYPHS_RST = CNT_W'(8);

  typedef enum logic [1:0] {
    ACT_BLANK = 2'd0,
    ACT_REUSE = 2'd1,
    ACT_NEW   = 2'd2,
    ACT_DROP  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_RESULT = 3'b100
  } state_e;

  typedef logic [PAT_W-1:0] pattern_t;

endpackage

@@ hw/rtl/glyph_table_dedup_top.sv @@
// Glyph table dedup: one character cell in, one placement decision out.
// Depends on gtd_pkg and glyph_table_dedup_top_defines.svh.
//
// Usage: the slave stream takes a cell request (tdata: masked-in glyph
//   pattern, column, line; tuser[0]: frame start, which clears the glyph table
//   and the stop flag first). The master stream returns one result request per
//   cell (tuser: action; tdata: glyph id, pattern to load, position). The cfg
//   channel writes max_glyphs (4 bits); it is always ready, so write it only
//   while no cell is in flight.
// Sequence: one cell at a time. A cell is accepted in the idle state, then
//   compared against one stored glyph per scan step up to the hit (plus an
//   end step when it misses), then emitted from the result state; blank
//   cells and stopped frames skip the compares. One 40-bit comparator walks
//   the glyph table, which holds 8 slots.
// Reset: glyph count and stop flag clear, max_glyphs returns to 8, both
//   streams go idle. Glyph storage is not cleared; only written slots are read.
// Stall: a finished result holds in the output register while the next cell
//   is taken; a second result waits in the result state, holding tready low.
`include "glyph_table_dedup_top_defines.svh"

module glyph_table_dedup_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // cell input
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [39:0] cell_pattern, [43:40] cell_col, [45:44] cell_line, [47:46] zero
  input  logic [gtd_pkg::S_DATA_W-1:0]  s_axis_tdata,
  // [0] frame_start
  input  logic                          s_axis_tuser,
  // result output
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [2:0] glyph_id, [42:3] glyph_pattern, [46:43] out_col,
  // [48:47] out_line, [55:49] zero
  output logic [gtd_pkg::M_DATA_W-1:0]  m_axis_tdata,
  // [1:0] action
  output logic [1:0]                    m_axis_tuser,
  // max_glyphs write
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [gtd_pkg::CNT_W-1:0]     cfg_data_i
);
  import gtd_pkg::*;

  state_e               state_q, state_d;
  pattern_t             pat_q;
  logic [3:0]           col_q;
  logic [1:0]           line_q;
  logic [CNT_W-1:0]     idx_q, idx_d;
  logic                 hit_q, hit_d;
  logic [IDX_W-1:0]     hit_id_q, hit_id_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic                 stopped_q, stopped_d;
  logic [CNT_W-1:0]     max_glyphs_q;
  pattern_t             store_q [SLOTS];

  logic                 out_valid_q, out_valid_d;
  logic [M_DATA_W-1:0]  out_data_q;
  logic [1:0]           out_user_q;

  logic                 s_fire;
  logic                 out_load;
  logic                 cell_blank;
  logic                 store_match;
  logic [CNT_W-1:0]     limit;
  logic [CNT_W-1:0]     count_inc;
  action_e              act;
  logic [IDX_W-1:0]     res_id;
  pattern_t             res_pat;
  pattern_t             in_pat;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign in_pat        = s_axis_tdata[PAT_W-1:0] & USED_MASK;

  // Limit above the slot count acts as the slot count.
  assign limit       = (max_glyphs_q > SLOTS_CNT) ? SLOTS_CNT : max_glyphs_q;
  assign count_inc   = count_q + CNT_W'(1);
  assign cell_blank  = (pat_q == '0);
  assign store_match = (store_q[idx_q[IDX_W-1:0]] == pat_q);
  assign out_load    = (state_q == ST_RESULT) && (!out_valid_q || m_axis_tready);

  // Decide the action from the scan outcome.
  always_comb begin
    act     = ACT_DROP;
    res_id  = '0;
    res_pat = '0;
    if (stopped_q) begin
      act = ACT_DROP;
    end else if (cell_blank) begin
      act = ACT_BLANK;
    end else if (hit_q) begin
      act    = ACT_REUSE;
      res_id = hit_id_q;
    end else if (count_q >= limit) begin
      act = ACT_DROP;
    end else begin
      act     = ACT_NEW;
      res_id  = count_q[IDX_W-1:0];
      res_pat = pat_q;
    end
  end

  // Sequencer: accept, walk the table one slot per cycle, emit.
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    hit_d       = hit_q;
    hit_id_d    = hit_id_q;
    count_d     = count_q;
    stopped_d   = stopped_q;
    out_valid_d = out_valid_q && !m_axis_tready;

    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          idx_d = '0;
          hit_d = 1'b0;
          if (s_axis_tuser) begin
            count_d   = '0;
            stopped_d = 1'b0;
          end
          // Skip the scan for blank cells and stopped frames.
          if ((stopped_q && !s_axis_tuser) || (in_pat == '0)) begin
            state_d = ST_RESULT;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (idx_q >= count_q) begin
          state_d = ST_RESULT;
        end else if (store_match) begin
          hit_d    = 1'b1;
          hit_id_d = idx_q[IDX_W-1:0];
          state_d  = ST_RESULT;
        end else begin
          idx_d = idx_q + CNT_W'(1);
        end
      end
      ST_RESULT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          if (!stopped_q && !cell_blank) begin
            if (act == ACT_NEW) begin
              count_d = count_inc;
            end
            // Stop the frame once the table is full after this cell.
            if (((act == ACT_NEW) ? count_inc : count_q) >= limit) begin
              stopped_d = 1'b1;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      hit_q        <= 1'b0;
      hit_id_q     <= '0;
      count_q      <= '0;
      stopped_q    <= 1'b0;
      max_glyphs_q <= MAX_GLYPHS_RST;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      hit_q       <= hit_d;
      hit_id_q    <= hit_id_d;
      count_q     <= count_d;
      stopped_q   <= stopped_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        max_glyphs_q <= cfg_data_i;
      end
    end
  end

  // Payload registers: cell capture, glyph storage, output register.
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      pat_q  <= in_pat;
      col_q  <= s_axis_tdata[PAT_W+3:PAT_W];
      line_q <= s_axis_tdata[PAT_W+5:PAT_W+4];
    end
    if (out_load && !stopped_q && !cell_blank && (act == ACT_NEW)) begin
      store_q[count_q[IDX_W-1:0]] <= pat_q;
    end
    if (out_load) begin
      out_data_q <= {(M_DATA_W - IDX_W - PAT_W - 6)'(0), line_q, col_q, res_pat, res_id};
      out_user_q <= act;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  `GTD_ASSERT_SAME(a_count_bound, 1'b1, count_q <= SLOTS_CNT, "glyph count above slot count")
  `GTD_ASSERT_SAME(a_scan_bound, state_q == ST_SCAN, idx_q <= count_q, "scan index past count")
  `GTD_ASSERT_NEXT(a_busy_after_accept, s_fire, !s_axis_tready, "ready during cell work")
  `GTD_ASSERT_NEXT(a_new_bumps_count,
    out_load && !stopped_q && !cell_blank && (act == ACT_NEW),
    count_q == $past(count_inc), "new glyph without count advance")

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for glyph_table_dedup_top: streams character cells in and
// checks every placement decision against a glyph table model kept alongside.
// Depends on gtd_pkg and the glyph_table_dedup_top RTL.
module testbench;
  import gtd_pkg::*;

  localparam int CELL_TARGET  = 1900;  // stop issuing random cells past this
  localparam int PHASE_CELLS  = 160;   // cells between limit changes
  localparam int STALL_LIMIT  = 2000;  // cycles with no handshake before giving up
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off to back the block up
  localparam int DRAIN_CYCLES = 12;    // worst-case latency plus margin

  // One expected placement decision, in the order the block must return it.
  typedef struct packed {
    action_e    act;
    logic [2:0] id;
    pattern_t   pat;
    logic [3:0] col;
    logic [1:0] line;
  } placement_t;

  // Receiver stall patterns; each one runs for a random window.
  typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_e;

  // Glyph table model plus the queue of placements still owed by the block.
  class placement_book;
    pattern_t         glyph_store [SLOTS];
    logic [CNT_W-1:0] glyph_count;
    bit               frame_stopped;
    logic [CNT_W-1:0] max_glyphs;
    placement_t       pending [$];
    int               errors;
    int               frames;
    int               limit_writes;
    int               seen [4];

    function new();
      glyph_count   = '0;
      frame_stopped = 1'b0;
      max_glyphs    = MAX_GLYPHS_RST;
      errors        = 0;
      frames        = 0;
      limit_writes  = 0;
      foreach (seen[i]) seen[i] = 0;
    endfunction

    function void set_limit(logic [CNT_W-1:0] value);
      max_glyphs = value;
      limit_writes++;
    endfunction

    // Work out the placement for an accepted cell and queue it.
    function void note_cell(bit fs, pattern_t cell_pat, logic [3:0] col, logic [1:0] line);
      pattern_t         pat;
      logic [CNT_W-1:0] lim;
      placement_t       r;
      bit               hit;
      pat = cell_pat & USED_MASK;
      lim = (max_glyphs > SLOTS_CNT) ? SLOTS_CNT : max_glyphs;
      if (fs) begin
        glyph_count   = '0;
        frame_stopped = 1'b0;
        frames++;
      end
      r.act  = ACT_BLANK;
      r.id   = '0;
      r.pat  = '0;
      r.col  = col;
      r.line = line;
      hit    = 1'b0;
      if (frame_stopped) begin
        r.act = ACT_DROP;
      end else if (pat != '0) begin
        // Search only the slots filled in this frame; take the lowest hit.
        for (int i = 0; i < SLOTS; i++) begin
          if (!hit && i < glyph_count && glyph_store[i] == pat) begin
            hit  = 1'b1;
            r.id = i[2:0];
          end
        end
        if (hit) begin
          r.act = ACT_REUSE;
        end else if (glyph_count >= lim) begin
          r.act = ACT_DROP;
        end else begin
          r.id                   = glyph_count[2:0];
          glyph_store[r.id]      = pat;
          glyph_count            = glyph_count + 1'b1;
          r.act                  = ACT_NEW;
          r.pat                  = pat;
        end
        // A full table, or a miss with no room, ends the frame.
        if (glyph_count >= lim) frame_stopped = 1'b1;
      end
      pending.push_back(r);
    endfunction

    task report(string what);
      errors++;
      $display("MISMATCH: %s", what);
    endtask

    task compare(string field, logic [PAT_W-1:0] got, logic [PAT_W-1:0] want);
      if (got !== want)
        report($sformatf("%s got 0x%0h, expected 0x%0h", field, got, want));
    endtask

    // Check a returned placement against the oldest one still owed.
    task check_placement(logic [1:0] act, logic [M_DATA_W-1:0] data);
      placement_t e;
      if (pending.size() == 0) begin
        report($sformatf("result action %0d with no cell outstanding", act));
      end else begin
        e = pending.pop_front();
        if (!$isunknown(act)) seen[act]++;
        compare("action", PAT_W'(act), PAT_W'(e.act));
        compare("glyph_id", PAT_W'(data[2:0]), PAT_W'(e.id));
        compare("glyph_pattern", data[42:3], e.pat);
        compare("out_col", PAT_W'(data[46:43]), PAT_W'(e.col));
        compare("out_line", PAT_W'(data[48:47]), PAT_W'(e.line));
      end
    endtask
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_axis_tdata;
  logic [1:0]            m_axis_tuser;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CNT_W-1:0]      cfg_data_i    = '0;

  placement_book book = new();

  int cells_sent = 0;
  int burst_left = 0;
  int quiet      = 0;
  bit hold_req   = 1'b0;

  glyph_table_dedup_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Sample every channel mid-cycle, where inputs and outputs are settled, so
  // a handshake seen here is the one taken at the next rising edge. Note the
  // cell before its result can possibly show up.
  always @(negedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready)
      book.note_cell(s_axis_tuser, s_axis_tdata[39:0], s_axis_tdata[43:40],
                     s_axis_tdata[45:44]);
    if (m_axis_tvalid && m_axis_tready)
      book.check_placement(m_axis_tuser, m_axis_tdata);
    if (cfg_valid_i && cfg_ready_o)
      book.set_limit(cfg_data_i);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      quiet = 0;
    else
      quiet++;
    if (quiet >= STALL_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
               STALL_LIMIT, book.pending.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: switch between stall patterns on random windows, and honor a
  // single long hold-off when the stimulus asks for one.
  initial begin
    rx_mode_e mode;
    int       window_left;
    int       hold_left;
    int       tick;
    mode        = RX_FREE;
    window_left = 0;
    hold_left   = 0;
    tick        = 0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (window_left == 0) begin
          mode        = rx_mode_e'($urandom_range(0, 3));
          window_left = $urandom_range(8, 80);
        end
        window_left--;
        case (mode)
          RX_FREE:   m_axis_tready <= 1'b1;
          RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: m_axis_tready <= (tick % 4 == 0);
          default:   m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Offer one cell and return at the edge that takes it. Bursts of random
  // length are separated by random gaps; some gaps are zero, so stretches of
  // back-to-back requests occur too.
  task automatic send_cell(bit fs, pattern_t pat, logic [3:0] col, logic [1:0] line);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if ($urandom_range(0, 19) == 0) gap = $urandom_range(15, 30);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, line, col, pat};
    s_axis_tuser  <= fs;
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    cells_sent++;
  endtask

  // Stop offering cells and wait until every owed result has come back.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (book.pending.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [CNT_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mix dense random patterns with sparse ones, so near-miss compares happen.
  function automatic pattern_t random_pattern();
    pattern_t p;
    p = pattern_t'({$urandom, $urandom});
    if ($urandom_range(0, 3) == 0) p = PAT_W'(1) << $urandom_range(0, PAT_W - 1);
    return p;
  endfunction

  // A frame of cells drawn mostly from a small palette so glyphs repeat; the
  // rest are blanks, stray patterns and the odd frame start in mid-frame.
  task automatic send_frame(bit open_frame);
    pattern_t palette [12];
    int       colors;
    int       len;
    int       pick;
    pattern_t pat;
    colors = $urandom_range(1, 11);
    len    = $urandom_range(1, 40);
    for (int i = 0; i < colors; i++) palette[i] = random_pattern();
    for (int i = 0; i < len && cells_sent < CELL_TARGET; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 12)      pat = '0;
      else if (pick < 20) pat = random_pattern();
      else                pat = palette[$urandom_range(0, colors - 1)];
      send_cell((i == 0 && open_frame) || ($urandom_range(0, 39) == 0), pat,
                4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
    end
  endtask

  initial begin
    int limit_plan [11];
    int phase;
    int mark;
    int phase_cells;
    bit first;
    limit_plan = '{1, 8, 3, 0, 15, 5, 9, 2, 7, 4, 6};

    // Hold reset once, at the start of the run.
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: fill all eight slots at the reset limit, with reuse, a blank,
    // and the extremes of pattern and position.
    send_cell(1'b1, {PAT_W{1'b1}}, 4'd15, 2'd3);
    send_cell(1'b0, '0, 4'd0, 2'd0);
    send_cell(1'b0, {PAT_W{1'b1}}, 4'd7, 2'd1);
    send_cell(1'b0, PAT_W'(1), 4'd1, 2'd2);
    send_cell(1'b0, PAT_W'(1) << (PAT_W - 1), 4'd2, 2'd0);
    send_cell(1'b0, 40'h55_5555_5555, 4'd3, 2'd1);
    send_cell(1'b0, 40'hAA_AAAA_AAAA, 4'd4, 2'd2);
    send_cell(1'b0, PAT_W'(2), 4'd5, 2'd3);
    send_cell(1'b0, PAT_W'(3), 4'd6, 2'd0);
    send_cell(1'b0, PAT_W'(4), 4'd8, 2'd1);
    // Table is now full: the frame is stopped, blanks and hits drop too.
    send_cell(1'b0, '0, 4'd9, 2'd2);
    send_cell(1'b0, {PAT_W{1'b1}}, 4'd10, 2'd3);
    // A frame start clears the table and the stop flag.
    send_cell(1'b1, '0, 4'd11, 2'd0);
    send_cell(1'b1, PAT_W'(1), 4'd12, 2'd1);
    wait_idle();

    // Limit zero: the first non-blank cell misses with no room and stops.
    write_limit(4'd0);
    send_cell(1'b1, PAT_W'(7), 4'd13, 2'd2);
    send_cell(1'b0, '0, 4'd14, 2'd3);
    wait_idle();

    // A limit above the slot count acts as the slot count.
    write_limit(4'd15);
    for (int i = 0; i < 9; i++)
      send_cell(i == 0, PAT_W'(i + 16), 4'(i), 2'(i));

    // Random phases, each under its own limit. About half of the phases continue
    // the previous frame, so the new limit lands mid-frame.
    phase = 0;
    while (cells_sent < CELL_TARGET) begin
      wait_idle();
      write_limit(phase < 11 ? CNT_W'(limit_plan[phase]) : CNT_W'($urandom_range(0, 15)));
      // Back the block up once: the receiver holds off while cells keep coming.
      if (phase == 1) hold_req = 1'b1;
      phase_cells = 0;
      first       = 1'b1;
      while (phase_cells < PHASE_CELLS && cells_sent < CELL_TARGET) begin
        mark = cells_sent;
        send_frame(!(first && $urandom_range(0, 1) == 1));
        first       = 1'b0;
        phase_cells += cells_sent - mark;
      end
      phase++;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d cells over %0d frame starts and %0d limit writes, with a %0d-cycle hold-off.",
             cells_sent, book.frames, book.limit_writes, HOLD_CYCLES);
    $display("Placements: %0d blank, %0d reused, %0d new, %0d dropped; %0d mismatches.",
             book.seen[ACT_BLANK], book.seen[ACT_REUSE], book.seen[ACT_NEW],
             book.seen[ACT_DROP], book.errors);
    if (book.errors == 0 && book.pending.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
